/* hdl/bpc_pkg.sv */
// Shared constants for the bipartition pairwise compatibility checker.
// No dependencies; the interfaces and the top level import this package.
package bpc_pkg;
	localparam int BPC_MAX_SPLITS = 128;
	localparam int BPC_MAX_TAXA   = 64;
	localparam int SPLIT_W        = 64;
	localparam int NUM_EL_W       = 7;
	localparam int IDX_OUT_W      = 7;
	localparam int CNT_OUT_W      = 8;
	localparam logic [NUM_EL_W-1:0] NUM_EL_RESET = 7'd64;
endpackage

/* hdl/bpc_if.sv */
// Valid/ready channel interfaces: split items in, result items out, config writes.
// Depends on bpc_pkg for field widths.
interface bpc_split_if import bpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPLIT_W-1:0] split_bits;
	logic               last;
	modport source (output valid, output split_bits, output last, input ready);
	modport sink   (input valid, input split_bits, input last, output ready);
endinterface

interface bpc_result_if import bpc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 all_compatible;
	logic [IDX_OUT_W-1:0] bad_first;
	logic [IDX_OUT_W-1:0] bad_second;
	logic [CNT_OUT_W-1:0] loaded_count;
	logic                 overflowed;
	modport source (output valid, output all_compatible, output bad_first, output bad_second,
		output loaded_count, output overflowed, input ready);
	modport sink   (input valid, input all_compatible, input bad_first, input bad_second,
		input loaded_count, input overflowed, output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NUM_EL_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/bpc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hdl/bpc_pair_unit.sv */
// Four-gamete test of two bipartitions over the counted taxa.
// No dependencies; shared by every pair the sequencer walks.
module bpc_pair_unit #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] mask,
	output logic             fail
);
	logic both, only_a, only_b, neither;

	always_comb begin
		both    = |(a & b & mask);
		only_a  = |(a & ~b & mask);
		only_b  = |(~a & b & mask);
		neither = |(~a & ~b & mask);
		fail    = both & only_a & only_b & neither;
	end
endmodule

/* hdl/bipartition_pairwise_compatibility.sv */
// Bipartition pairwise compatibility checker, top level.
// Uses bpc_pkg, the channel interfaces, bpc_ram and bpc_pair_unit.
//
// Usage: items arrive on splits, one bipartition per item; each is written to
// the split store at one item per cycle. Once the store holds MAX_SPLITS
// vectors, further items are dropped and the overflow flag is set. An item
// with last set (stored or dropped) ends the set and starts the check; splits
// stays not ready until the result item has been taken on result.
// The check reads one stored vector per cycle through the single RAM read port
// and runs one four-gamete pair test per cycle in the shared pair unit. The
// result is shown once every pair has passed or at the first failing pair;
// fewer than two vectors give the result in the next cycle.
// The result holds while result.ready is low; once taken, the count and
// overflow flag clear and loading resumes. cfg writes num_elements at any
// time and is always ready; the value in force at the last item is used.
// Reset: num_elements returns to 64, the store is empty, no result pending.
// The store contents are not cleared; only entries of the current set are read.
module bipartition_pairwise_compatibility import bpc_pkg::*; #(
	parameter int MAX_SPLITS = BPC_MAX_SPLITS,
	parameter int MAX_TAXA   = BPC_MAX_TAXA
) (
	input logic              clk,
	input logic              arst_n,
	bpc_split_if.sink        splits,
	bpc_result_if.source     result,
	bpc_cfg_if.sink          cfg
);
	localparam int IDX_W = $clog2(MAX_SPLITS);
	localparam int CNT_W = $clog2(MAX_SPLITS + 1);

	typedef enum logic [2:0] {S_LOAD, S_ROW, S_ROWDAT, S_SCAN, S_OUT} state_t;

	state_t                state_q;
	logic [NUM_EL_W-1:0]   num_el_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  ovf_q;
	logic [IDX_W-1:0]      i_q;
	logic [CNT_W-1:0]      j_q;
	logic [IDX_W-1:0]      pj_s1;
	logic [MAX_TAXA-1:0]   a_q;
	logic [MAX_TAXA-1:0]   mask_q;
	logic                  ok_q;
	logic [IDX_OUT_W-1:0]  first_q;
	logic [IDX_OUT_W-1:0]  second_q;

	logic                  in_fire, full, ram_re, pair_fail, more_rows;
	logic [CNT_W-1:0]      cnt_next;
	logic [IDX_W-1:0]      raddr;
	logic [MAX_TAXA-1:0]   rdata, mask_n;
	logic [NUM_EL_W-1:0]   n_sat;
	logic [31:0]           i_w, pj_w, cnt_w;

	assign in_fire      = splits.valid && splits.ready;
	assign full         = (cnt_q == CNT_W'(MAX_SPLITS));
	assign cnt_next     = full ? cnt_q : cnt_q + CNT_W'(1);
	assign splits.ready = (state_q == S_LOAD);
	assign cfg.ready    = 1'b1;
	assign more_rows    = ((CNT_W+1)'(i_q) + (CNT_W+1)'(2)) < (CNT_W+1)'(cnt_q);
	assign i_w          = 32'(i_q);
	assign pj_w         = 32'(pj_s1);
	assign cnt_w        = 32'(cnt_q);

	always_comb begin
		n_sat = (num_el_q > NUM_EL_W'(MAX_TAXA)) ? NUM_EL_W'(MAX_TAXA) : num_el_q;
		for (int k = 0; k < MAX_TAXA; k++) begin
			mask_n[k] = (NUM_EL_W+1)'(k) < (NUM_EL_W+1)'(n_sat);
		end
	end

	always_comb begin
		ram_re = 1'b1;
		case (state_q)
			S_ROW:    raddr = i_q;
			S_ROWDAT: raddr = i_q + IDX_W'(1);
			S_SCAN:   raddr = j_q[IDX_W-1:0];
			default: begin
				raddr  = i_q;
				ram_re = 1'b0;
			end
		endcase
	end

	bpc_ram #(.WIDTH(MAX_TAXA), .DEPTH(MAX_SPLITS)) u_store (
		.clk   (clk),
		.we    (in_fire && !full),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (splits.split_bits[MAX_TAXA-1:0]),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	bpc_pair_unit #(.WIDTH(MAX_TAXA)) u_pair (
		.a    (a_q),
		.b    (rdata),
		.mask (mask_q),
		.fail (pair_fail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			num_el_q <= NUM_EL_RESET;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			pj_s1    <= '0;
			a_q      <= '0;
			mask_q   <= '0;
			ok_q     <= 1'b1;
			first_q  <= '0;
			second_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				num_el_q <= cfg.data;
			end
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						cnt_q <= cnt_next;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (splits.last) begin
							mask_q   <= mask_n;
							i_q      <= '0;
							ok_q     <= 1'b1;
							first_q  <= '0;
							second_q <= '0;
							state_q  <= (cnt_next >= CNT_W'(2)) ? S_ROW : S_OUT;
						end
					end
				end
				S_ROW: begin
					state_q <= S_ROWDAT;
				end
				S_ROWDAT: begin
					a_q     <= rdata;
					pj_s1   <= i_q + IDX_W'(1);
					j_q     <= CNT_W'(i_q) + CNT_W'(2);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (pair_fail) begin
						ok_q     <= 1'b0;
						first_q  <= i_w[IDX_OUT_W-1:0];
						second_q <= pj_w[IDX_OUT_W-1:0];
						state_q  <= S_OUT;
					end else if (j_q == cnt_q) begin
						if (more_rows) begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= S_ROW;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						pj_s1 <= j_q[IDX_W-1:0];
						j_q   <= j_q + CNT_W'(1);
					end
				end
				S_OUT: begin
					if (result.ready) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign result.valid          = (state_q == S_OUT);
	assign result.all_compatible = ok_q;
	assign result.bad_first      = first_q;
	assign result.bad_second     = second_q;
	assign result.loaded_count   = cnt_w[CNT_OUT_W-1:0];
	assign result.overflowed     = ovf_q;

`ifndef NO_ASSERTIONS
	a_no_intake_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		splits.ready |-> !result.valid)
		else $error("split intake open while a result is pending");
	a_scan_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((32'(i_q) < pj_w) && (pj_w < cnt_w)))
		else $error("scanned pair outside the stored range");
	a_pass_zero_indices: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.all_compatible) |->
		(result.bad_first == '0 && result.bad_second == '0))
		else $error("passing result carries a failing pair");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_w <= 32'(MAX_SPLITS))
		else $error("stored count beyond capacity");
`endif
endmodule
